// ===== src/rle_marker_encoder_assert.svh =====
// Assertion macros shared by the run-length encoder modules.
`ifndef RLE_MARKER_ENCODER_ASSERT_SVH
`define RLE_MARKER_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RME_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/rme_pkg.sv =====
// Types, constants and helper functions of the run-length encoder.
package rme_pkg;

	localparam int unsigned RME_MAX_RUN = 65520;

	localparam logic [7:0]  ESC_MARKER    = 8'hFE;
	localparam logic [15:0] MIN_CODED_RUN = 16'd4;
	localparam logic [2:0]  CODED_LEN     = 3'd4;

	localparam logic [1:0] POS_MARKER = 2'd0;
	localparam logic [1:0] POS_LEN_LO = 2'd1;
	localparam logic [1:0] POS_LEN_HI = 2'd2;
	localparam logic [1:0] POS_VALUE  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_in;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       step_done;
		logic       stream_end;
	} out_t;

	typedef struct packed {
		logic [7:0]  a_value;
		logic [15:0] a_count;
		logic [2:0]  a_len;
		logic [7:0]  b_value;
		logic [15:0] b_count;
		logic [2:0]  b_len;
		logic        fin;
	} job_t;

	function automatic logic [2:0] run_len(input logic [7:0] value, input logic [15:0] count);
		if (count < MIN_CODED_RUN && value != ESC_MARKER) begin
			return {1'b0, count[1:0]};
		end
		return CODED_LEN;
	endfunction

	function automatic logic [7:0] run_byte(input logic [7:0] value, input logic [15:0] count,
			input logic [2:0] len, input logic [1:0] pos);
		logic [7:0] b;
		if (!len[2]) begin
			b = value;
		end else begin
			case (pos)
				POS_MARKER: b = ESC_MARKER;
				POS_LEN_LO: b = count[7:0];
				POS_LEN_HI: b = count[15:8];
				POS_VALUE:  b = value;
				default:    b = value;
			endcase
		end
		return b;
	endfunction

endpackage

// ===== src/rle_marker_encoder.sv =====
// A run-ending transaction loads the job register; the job's first byte then loads out_q.
// One input transaction per cycle while each needs at most one output byte and output is
// not stalled; the emitter sends one byte per cycle then, and input waits for a job's end.
// Jobs of up to eight bytes come from one closed run plus a flushed final run.
// Reset (arst_n low, asynchronous) clears the pending run and empties job and output.
// Top level of the escape-marker run-length encoder.
module rle_marker_encoder import rme_pkg::*; #(
	parameter int unsigned MAX_RUN = RME_MAX_RUN
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_item
);

	job_t job;
	logic has_bytes;
	logic accept;
	logic job_free;

	assign in_ready = job_free;
	assign accept   = in_valid && in_ready;

	rme_run_tracker #(
		.MAX_RUN(MAX_RUN)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (in_item),
		.job      (job),
		.has_bytes(has_bytes)
	);

	rme_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_push (accept && has_bytes),
		.job_in   (job),
		.job_free (job_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

endmodule

// ===== src/rme_run_tracker.sv =====
// Run tracking: holds the pending run and builds the byte job for each transaction.
module rme_run_tracker import rme_pkg::*; #(
	parameter int unsigned MAX_RUN = RME_MAX_RUN
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  in_t  item,
	output job_t job,
	output logic has_bytes
);

	`include "rle_marker_encoder_assert.svh"

	localparam logic [15:0] MaxRunW = 16'(MAX_RUN);

	logic [7:0]  val_q;
	logic [15:0] cnt_q;
	logic        closing;
	logic [7:0]  nxt_val;
	logic [15:0] nxt_cnt;

	always_comb begin
		closing = (cnt_q != 16'd0) && ((item.data_byte != val_q) || (cnt_q >= MaxRunW));
		if (closing || cnt_q == 16'd0) begin
			nxt_val = item.data_byte;
			nxt_cnt = 16'd1;
		end else begin
			nxt_val = val_q;
			nxt_cnt = cnt_q + 16'd1;
		end
		job.a_value = val_q;
		job.a_count = cnt_q;
		job.a_len   = closing ? run_len(val_q, cnt_q) : 3'd0;
		job.b_value = nxt_val;
		job.b_count = nxt_cnt;
		job.b_len   = item.final_in ? run_len(nxt_val, nxt_cnt) : 3'd0;
		job.fin     = item.final_in;
		has_bytes   = closing || item.final_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 8'd0;
			cnt_q <= 16'd0;
		end else if (accept) begin
			if (item.final_in) begin
				val_q <= 8'd0;
				cnt_q <= 16'd0;
			end else begin
				val_q <= nxt_val;
				cnt_q <= nxt_cnt;
			end
		end
	end

	`RME_ASSERT_IMPL(a_cnt_capped, clk, arst_n, 1'b1, cnt_q <= MaxRunW)
	`RME_ASSERT_NEXT(a_final_clears, clk, arst_n, accept && item.final_in, cnt_q == 16'd0)

endmodule

// ===== src/rme_emitter.sv =====
// Byte emitter: walks one job's bytes into the output register.
module rme_emitter import rme_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_push,
	input  job_t job_in,
	output logic job_free,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_item
);

	`include "rle_marker_encoder_assert.svh"

	job_t       job_q;
	logic       job_valid_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	out_t       out_q;

	logic [3:0] total;
	logic       last;
	logic       load;
	logic [2:0] b_idx;
	out_t       nxt_out;

	always_comb begin
		total = {1'b0, job_q.a_len} + {1'b0, job_q.b_len};
		last  = ({1'b0, idx_q} + 4'd1) == total;
		load  = job_valid_q && (!out_valid_q || out_ready);
		b_idx = idx_q - job_q.a_len;
		if (idx_q < job_q.a_len) begin
			nxt_out.out_byte = run_byte(job_q.a_value, job_q.a_count, job_q.a_len, idx_q[1:0]);
		end else begin
			nxt_out.out_byte = run_byte(job_q.b_value, job_q.b_count, job_q.b_len, b_idx[1:0]);
		end
		nxt_out.step_done  = last;
		nxt_out.stream_end = last && job_q.fin;
		job_free = !job_valid_q || (load && last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_push) begin
				job_valid_q <= 1'b1;
				idx_q       <= 3'd0;
			end else if (load && last) begin
				job_valid_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) begin
			job_q <= job_in;
		end
		if (load) begin
			out_q <= nxt_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`RME_ASSERT_IMPL(a_job_nonempty, clk, arst_n, job_valid_q, total != 4'd0)
	`RME_ASSERT_IMPL(a_idx_in_range, clk, arst_n, job_valid_q, {1'b0, idx_q} < total)
	`RME_ASSERT_IMPL(a_end_is_done, clk, arst_n, out_valid_q, !out_q.stream_end || out_q.step_done)
	`RME_ASSERT_IMPL(a_push_when_free, clk, arst_n, job_push, job_free)

endmodule

// ===== dv/tb_rle_marker_encoder.sv =====
// Self-checking testbench of the escape-marker run-length encoder, with directed and random streams.
module tb_rle_marker_encoder import rme_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_item;

	bit          idle_en = 1'b1;
	int          failures = 0;
	int unsigned cycles = 0;
	int          sink_stall = 0;

	logic [7:0]  run_val = '0;
	logic [15:0] run_cnt = '0;
	out_t        step_bytes[$];
	out_t        expected_bytes[$];
	out_t        want;

	rle_marker_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			out_ready  <= (sink_stall == 1);
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			sink_stall <= $urandom_range(1, 4);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected output byte %02h", out_item.out_byte);
				failures++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_item.out_byte);
					failures++;
				end
				if (out_item.step_done !== want.step_done) begin
					$error("step_done: expected %0b, got %0b", want.step_done, out_item.step_done);
					failures++;
				end
				if (out_item.stream_end !== want.stream_end) begin
					$error("stream_end: expected %0b, got %0b", want.stream_end,
						out_item.stream_end);
					failures++;
				end
			end
		end
	end

	function automatic void add_run(input logic [7:0] v, input logic [15:0] c);
		out_t o;
		o = '0;
		if (c < MIN_CODED_RUN && v != ESC_MARKER) begin
			o.out_byte = v;
			repeat (c) step_bytes.push_back(o);
		end else begin
			o.out_byte = ESC_MARKER;
			step_bytes.push_back(o);
			o.out_byte = c[7:0];
			step_bytes.push_back(o);
			o.out_byte = c[15:8];
			step_bytes.push_back(o);
			o.out_byte = v;
			step_bytes.push_back(o);
		end
	endfunction

	function automatic void encode_byte(input in_t it);
		step_bytes.delete();
		if (run_cnt != 0 && (it.data_byte != run_val || run_cnt >= RME_MAX_RUN)) begin
			add_run(run_val, run_cnt);
			run_cnt = '0;
		end
		if (run_cnt == 0) begin
			run_val = it.data_byte;
			run_cnt = 16'd1;
		end else begin
			run_cnt = run_cnt + 16'd1;
		end
		if (it.final_in) begin
			add_run(run_val, run_cnt);
			run_cnt = '0;
			run_val = '0;
		end
		if (step_bytes.size() > 0) begin
			step_bytes[step_bytes.size() - 1].step_done  = 1'b1;
			step_bytes[step_bytes.size() - 1].stream_end = it.final_in;
		end
		foreach (step_bytes[i]) begin
			expected_bytes.push_back(step_bytes[i]);
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0, 1: return ESC_MARKER;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic fin);
		in_t item;
		item.data_byte = data;
		item.final_in  = fin;
		in_item  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		encode_byte(item);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_run(input logic [7:0] v, input int len, input logic fin_last);
		for (int k = 1; k <= len; k++) begin
			send_byte(v, fin_last && (k == len));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic random_streams(input int n_items);
		int sent;
		int n_runs;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				n_runs = $urandom_range(1, 8);
				for (int r = 0; r < n_runs; r++) begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 5);
					send_run(pick_byte(), len, (r == n_runs - 1) && ($urandom_range(0, 5) != 0));
					sent += len;
				end
			end
		end
		send_byte(pick_byte(), 1'b1);
		drain();
	endtask

	task automatic test_literals();
		send_byte(8'h00, 1'b1);
		send_run(8'h41, 3, 1'b0);
		send_byte(8'h42, 1'b0);
		send_run(8'hFF, 3, 1'b1);
		drain();
	endtask

	task automatic test_coded_runs();
		send_run(8'h00, 4, 1'b0);
		send_byte(ESC_MARKER, 1'b0);
		send_byte(ESC_MARKER, 1'b1);
		send_byte(8'h37, 1'b1);
		send_run(8'h80, 3, 1'b0);
		send_byte(8'h01, 1'b1);
		send_run(8'h7F, 5, 1'b0);
		send_byte(ESC_MARKER, 1'b1);
		drain();
	endtask

	task automatic test_long_run();
		send_run(8'hA5, 258, 1'b0);
		send_byte(8'h3C, 1'b1);
		drain();
	endtask

	task automatic test_run_cap();
		send_run(8'h5A, RME_MAX_RUN, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'h5A, 1'b1);
		drain();
	endtask

	task automatic test_random_streams();
		random_streams(360);
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		random_streams(40);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_literals();
		test_coded_runs();
		test_long_run();
		test_run_cap();
		test_random_streams();
		test_back_to_back();
		drain();
		repeat (8) @(posedge clk);
		if (failures == 0 && expected_bytes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/rme_pkg.sv
src/rme_run_tracker.sv
src/rme_emitter.sv
src/rle_marker_encoder.sv
dv/tb_rle_marker_encoder.sv
